### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SWA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("apodizer assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SWA_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("apodizer assertion failed");

`endif

### src/swa_pkg.sv
// ----------------------------------------------------------------------------
// swa_pkg
// Shared types, codes and constant functions of the spectral window apodizer.
// ----------------------------------------------------------------------------
package swa_pkg;

    localparam int SAMPLE_W     = 32;
    localparam int FRONT_STAGES = 5;
    localparam int BACK_STAGES  = 4;

    localparam logic [6:0] APEX_OFF = 7'd50;
    localparam logic [6:0] PERCENT  = 7'd100;

    // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT for every x below 2^32.
    localparam logic [31:0] DIV100_MUL   = 32'd2748779070;
    localparam int          DIV100_SHIFT = 38;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    typedef enum logic [2:0] {
        WIN_SQUARE   = 3'd0,
        WIN_PARZEN   = 3'd1,
        WIN_HANNING  = 3'd2,
        WIN_WELCH    = 3'd3,
        WIN_TRIANGLE = 3'd4
    } t_win;

    typedef enum logic [2:0] {
        CFG_WINDOW_TYPE   = 3'd0,
        CFG_COMPLEX_PAIRS = 3'd1,
        CFG_START_INDEX   = 3'd2,
        CFG_STOP_INDEX    = 3'd3,
        CFG_APEX_PERCENT  = 3'd4,
        CFG_POINT_COUNT   = 3'd5
    } t_cfg_idx;

    // Item payload and flags that travel alongside the ramp division.
    typedef struct packed {
        logic                in_span;
        logic                rone;
        logic [SAMPLE_W-1:0] re;
        logic [SAMPLE_W-1:0] im;
    } t_side;

    // One cosine table entry: angle 2*pi*k/2^ld folded into the first quarter,
    // Taylor series in Q30, truncated to f fraction bits.
    function automatic int swa_cos_entry(int unsigned k, int unsigned ld, int unsigned f);
        logic [63:0]        a;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        mag;
        logic signed [63:0] sum;
        logic               neg;
        a   = (64'd2 * PI_Q30 * 64'(k)) >> ld;
        neg = 1'b0;
        if (a > PI_Q30) begin
            a = 64'd2 * PI_Q30 - a;
        end
        if (a > (PI_Q30 >> 1)) begin
            a   = PI_Q30 - a;
            neg = 1'b1;
        end
        x2   = (a * a) >> 30;
        term = Q30_ONE;
        sum  = signed'(Q30_ONE);
        for (int i = 1; i <= 12; i++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * i - 1) * (2 * i));
            if (i[0]) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > signed'(Q30_ONE)) begin
            sum = signed'(Q30_ONE);
        end
        mag = 64'(sum) >> (30 - f);
        return neg ? -int'(mag) : int'(mag);
    endfunction

endpackage

### src/spectral_window_apodizer_unit.sv
// ----------------------------------------------------------------------------
// spectral_window_apodizer_unit
// Streaming FFT window apodizer with optional apex skew ramp.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle, unless every stage is full and the
// output is stalled, and returns one item for each item taken, in order. The
// pipeline depth is set by the two restoring dividers, which resolve one
// quotient bit per pipeline stage and run side by side: one produces the ramp
// coefficient and the other the window ratio or the cosine table index. Five
// front stages build the window span and the divider operands, and four back
// stages apply the coefficients and hold the result. A stalled output holds
// back only the run of full stages next to it; stages above a bubble keep
// filling. Configuration registers may be written only while no item is in
// flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spectral_window_apodizer_unit import swa_pkg::*; #(
    parameter int INDEX_BITS      = 16,
    parameter int COS_TABLE_DEPTH = 1024,
    parameter int COEF_FRAC_BITS  = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write port
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [16:0]                i_cfg_data,
    // input item channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [15:0]                i_position,
    input  logic signed [SAMPLE_W-1:0] i_sample_re,
    input  logic signed [SAMPLE_W-1:0] i_sample_im,
    // result item channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_result_re,
    output logic signed [SAMPLE_W-1:0] o_result_im
);

    // Derived sizes. The cosine table depth is taken to be a power of two.
    localparam int LD = $clog2(COS_TABLE_DEPTH);
    localparam int QW = (COEF_FRAC_BITS + 1 > LD + 2) ? (COEF_FRAC_BITS + 1) : (LD + 2);
    localparam int NW = INDEX_BITS + 1 + ((COEF_FRAC_BITS > LD) ? COEF_FRAC_BITS : LD);
    localparam int DW = INDEX_BITS + 1;
    localparam int NS = FRONT_STAGES + QW + BACK_STAGES;

    // Configuration registers.
    logic [2:0]  r_window_type;
    logic        r_complex;
    logic [15:0] r_start;
    logic [15:0] r_stop;
    logic [6:0]  r_apex;
    logic [16:0] r_point_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_type <= 3'd0;
            r_complex     <= 1'b0;
            r_start       <= 16'd0;
            r_stop        <= 16'hFFFF;
            r_apex        <= APEX_OFF;
            r_point_count <= 17'h10000;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WINDOW_TYPE:   r_window_type <= i_cfg_data[2:0];
                CFG_COMPLEX_PAIRS: r_complex     <= i_cfg_data[0];
                CFG_START_INDEX:   r_start       <= i_cfg_data[15:0];
                CFG_STOP_INDEX:    r_stop        <= i_cfg_data[15:0];
                CFG_APEX_PERCENT:  r_apex        <= i_cfg_data[6:0];
                CFG_POINT_COUNT:   r_point_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Pipeline occupancy. A stage may load when it or any stage below it down to
    // the output is empty, or when the output is taken, so each stage's enable
    // depends only on its own valid bit, those beneath it and the output ready.
    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_en;
    localparam logic [NS-1:0] ALL_FULL = '1;

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            w_en[k] = i_out_ready || ((r_vld >> k) != (ALL_FULL >> k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= (k == 0) ? i_in_valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NS-1];

    // Front end: span, membership and divider operands.
    logic [NW-1:0] w_rnum, w_wnum;
    logic [DW-1:0] w_rden, w_wden;
    logic          w_wzero_f;
    t_side         w_side_f;

    swa_front #(
        .IB (INDEX_BITS),
        .F  (COEF_FRAC_BITS),
        .LD (LD),
        .NW (NW),
        .DW (DW)
    ) u_front (
        .i_clk         (i_clk),
        .i_en          (w_en[FRONT_STAGES-1:0]),
        .i_position    (i_position),
        .i_sample_re   (i_sample_re),
        .i_sample_im   (i_sample_im),
        .i_complex     (r_complex),
        .i_window_type (r_window_type),
        .i_start       (r_start),
        .i_stop        (r_stop),
        .i_apex        (r_apex),
        .i_point_count (r_point_count),
        .o_rnum        (w_rnum),
        .o_rden        (w_rden),
        .o_wnum        (w_wnum),
        .o_wden        (w_wden),
        .o_wzero       (w_wzero_f),
        .o_side        (w_side_f)
    );

    // Ramp divider, which also carries the samples and flags.
    logic [QW-1:0] w_rquo;
    t_side         w_rside;

    swa_div #(
        .NW  (NW),
        .DW  (DW),
        .QW  (QW),
        .SBW ($bits(t_side))
    ) u_ramp_div (
        .i_clk  (i_clk),
        .i_en   (w_en[FRONT_STAGES +: QW]),
        .i_num  (w_rnum),
        .i_den  (w_rden),
        .i_side (w_side_f),
        .o_quo  (w_rquo),
        .o_side (w_rside)
    );

    // Window divider.
    logic [QW-1:0] w_wquo;
    logic          w_wzero;

    swa_div #(
        .NW  (NW),
        .DW  (DW),
        .QW  (QW),
        .SBW (1)
    ) u_win_div (
        .i_clk  (i_clk),
        .i_en   (w_en[FRONT_STAGES +: QW]),
        .i_num  (w_wnum),
        .i_den  (w_wden),
        .i_side (w_wzero_f),
        .o_quo  (w_wquo),
        .o_side (w_wzero)
    );

    // Back end: coefficients, products and the output register.
    swa_scale #(
        .F  (COEF_FRAC_BITS),
        .D  (COS_TABLE_DEPTH),
        .QW (QW)
    ) u_scale (
        .i_clk         (i_clk),
        .i_en          (w_en[FRONT_STAGES + QW +: BACK_STAGES]),
        .i_window_type (r_window_type),
        .i_wquo        (w_wquo),
        .i_wzero       (w_wzero),
        .i_rquo        (w_rquo),
        .i_side        (w_rside),
        .o_result_re   (o_result_re),
        .o_result_im   (o_result_im)
    );

    // A ramp quotient only means something for a valid item inside the span;
    // for items outside it the operands come from a wrapped offset.
    logic w_ramp_live;
    assign w_ramp_live = r_vld[FRONT_STAGES+QW-1] && w_rside.in_span && !w_rside.rone;

    // The input is refused only while every stage is full and the output waits.
    `SWA_ASSERT_IMP(a_refuse_only_when_full, !o_in_ready, o_out_valid && !i_out_ready)
    // An accepted item occupies the first stage on the next cycle.
    `SWA_ASSERT_NXT(a_entry_taken, i_in_valid && o_in_ready, r_vld[0])
    // An item behind an empty output register moves into it.
    `SWA_ASSERT_NXT(a_tail_moves, r_vld[NS-2] && !r_vld[NS-1], o_out_valid)
    // The ramp coefficient never exceeds one.
    `SWA_ASSERT_IMP(a_ramp_range, w_ramp_live, w_rquo <= (QW'(1) << COEF_FRAC_BITS))

endmodule

### src/swa_front.sv
// ----------------------------------------------------------------------------
// swa_front
// Five-stage front end: span, membership, apex offset and divider operands.
// ----------------------------------------------------------------------------
module swa_front import swa_pkg::*; #(
    parameter int IB = 16,
    parameter int F  = 16,
    parameter int LD = 10,
    parameter int NW = 27,
    parameter int DW = 17
) (
    input  logic                      i_clk,
    input  logic [FRONT_STAGES-1:0]   i_en,
    input  logic [15:0]               i_position,
    input  logic [SAMPLE_W-1:0]       i_sample_re,
    input  logic [SAMPLE_W-1:0]       i_sample_im,
    input  logic                      i_complex,
    input  logic [2:0]                i_window_type,
    input  logic [15:0]               i_start,
    input  logic [15:0]               i_stop,
    input  logic [6:0]                i_apex,
    input  logic [16:0]               i_point_count,
    output logic [NW-1:0]             o_rnum,
    output logic [DW-1:0]             o_rden,
    output logic [NW-1:0]             o_wnum,
    output logic [DW-1:0]             o_wden,
    output logic                      o_wzero,
    output t_side                     o_side
);

    localparam int PW  = (IB > 17) ? IB : 17;
    localparam int PRW = IB + 7;

    // Stage 1: sorted and clamped span.
    logic [IB-1:0]       w_sa, w_sb, w_s, w_e0, w_e;
    logic                w_pc0;
    logic [IB-1:0]       r1_pos, r1_s, r1_e;
    logic                r1_pc0;
    logic [SAMPLE_W-1:0] r1_re, r1_im;

    always_comb begin
        w_sa  = IB'(i_start);
        w_sb  = IB'(i_stop);
        w_s   = (w_sa > w_sb) ? w_sb : w_sa;
        w_e0  = (w_sa > w_sb) ? w_sa : w_sb;
        w_pc0 = (i_point_count == 17'd0);
        w_e   = (!w_pc0 && (PW'(w_e0) >= PW'(i_point_count)))
              ? IB'(i_point_count - 17'd1) : w_e0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_pos <= IB'(i_position);
            r1_s   <= w_s;
            r1_e   <= w_e;
            r1_pc0 <= w_pc0;
            r1_re  <= i_sample_re;
            r1_im  <= i_complex ? i_sample_im : '0;
        end
    end

    // Stage 2: membership, offset into the window and window length.
    logic                r2_inside;
    logic [IB-1:0]       r2_n, r2_len;
    logic [SAMPLE_W-1:0] r2_re, r2_im;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_inside <= !r1_pc0 && (r1_s <= r1_e) && (r1_pos >= r1_s) && (r1_pos <= r1_e);
            r2_n      <= r1_pos - r1_s;
            r2_len    <= r1_e - r1_s;
            r2_re     <= r1_re;
            r2_im     <= r1_im;
        end
    end

    // Stage 3: length times the saturated apex percentage.
    logic [6:0]          w_p;
    logic                r3_inside;
    logic [IB-1:0]       r3_n, r3_len;
    logic [PRW-1:0]      r3_prod;
    logic [SAMPLE_W-1:0] r3_re, r3_im;

    assign w_p = (i_apex > PERCENT) ? PERCENT : i_apex;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_prod   <= PRW'(r2_len) * PRW'(w_p);
            r3_inside <= r2_inside;
            r3_n      <= r2_n;
            r3_len    <= r2_len;
            r3_re     <= r2_re;
            r3_im     <= r2_im;
        end
    end

    // Stage 4: apex offset from the window start, divided by 100 through a reciprocal.
    logic [PRW+31:0]     w_big;
    logic                r4_inside;
    logic [IB-1:0]       r4_n, r4_len, r4_aoff;
    logic [SAMPLE_W-1:0] r4_re, r4_im;

    assign w_big = (PRW + 32)'(r3_prod) * (PRW + 32)'(DIV100_MUL);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r4_aoff   <= w_big[DIV100_SHIFT +: IB];
            r4_inside <= r3_inside;
            r4_n      <= r3_n;
            r4_len    <= r3_len;
            r4_re     <= r3_re;
            r4_im     <= r3_im;
        end
    end

    // Stage 5: dividend and divisor for the ramp and for the window.
    logic [IB+1:0] w_n2p1, w_n2, w_lx, w_d, w_tri;
    logic [NW-1:0] w_rnum, w_wnum;
    logic [DW-1:0] w_rden, w_wden;
    logic          w_rone, w_wzero;

    always_comb begin
        w_n2p1 = {1'b0, r4_n, 1'b1};
        w_n2   = {1'b0, r4_n, 1'b0};
        w_lx   = (IB + 2)'(r4_len);
        w_d    = (w_n2p1 >= w_lx) ? (w_n2p1 - w_lx) : (w_lx - w_n2p1);
        w_tri  = (w_n2 <= w_lx) ? w_n2 : ({1'b0, r4_len, 1'b0} - w_n2);

        w_rone = 1'b1;
        w_rnum = '0;
        w_rden = DW'(1);
        if (i_apex != APEX_OFF) begin
            if (r4_n < r4_aoff) begin
                w_rone = 1'b0;
                w_rnum = NW'(r4_n) << F;
                w_rden = DW'(r4_aoff);
            end else if (r4_n < r4_len) begin
                w_rone = 1'b0;
                w_rnum = NW'(r4_len - r4_n) << F;
                w_rden = DW'(r4_len - r4_aoff);
            end
        end

        w_wzero = 1'b0;
        w_wnum  = '0;
        w_wden  = DW'(1);
        unique case (t_win'(i_window_type))
            WIN_PARZEN, WIN_WELCH: begin
                w_wnum = NW'(w_d) << F;
                w_wden = DW'(r4_len) + DW'(1);
            end
            WIN_HANNING: begin
                w_wzero = (r4_len < IB'(2));
                w_wnum  = NW'(r4_n) << LD;
                w_wden  = w_wzero ? DW'(1) : (DW'(r4_len) - DW'(1));
            end
            WIN_TRIANGLE: begin
                w_wzero = (r4_len == '0);
                w_wnum  = NW'(w_tri) << F;
                w_wden  = w_wzero ? DW'(1) : DW'(r4_len);
            end
            default: begin
                w_wzero = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            o_rnum         <= w_rnum;
            o_rden         <= w_rden;
            o_wnum         <= w_wnum;
            o_wden         <= w_wden;
            o_wzero        <= w_wzero;
            o_side.in_span <= r4_inside;
            o_side.rone    <= w_rone;
            o_side.re      <= r4_re;
            o_side.im      <= r4_im;
        end
    end

endmodule

### src/swa_div.sv
// ----------------------------------------------------------------------------
// swa_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module swa_div import swa_pkg::*; #(
    parameter int NW  = 27,
    parameter int DW  = 17,
    parameter int QW  = 17,
    parameter int SBW = 1
) (
    input  logic             i_clk,
    input  logic [QW-1:0]    i_en,
    input  logic [NW-1:0]    i_num,
    input  logic [DW-1:0]    i_den,
    input  logic [SBW-1:0]   i_side,
    output logic [QW-1:0]    o_quo,
    output logic [SBW-1:0]   o_side
);

    // The quotient must be below 2^QW; the caller keeps it there for items inside the span.
    logic [NW-1:0]  r_rem  [QW-1];
    logic [DW-1:0]  r_den  [QW-1];
    logic [QW-1:0]  r_quo  [QW];
    logic [SBW-1:0] r_side [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int K = QW - 1 - j;
        logic [NW-1:0]  w_rem;
        logic [DW-1:0]  w_den;
        logic [QW-1:0]  w_quo;
        logic [SBW-1:0] w_side;
        logic           w_take;

        if (j == 0) begin : g_first
            assign w_rem  = i_num;
            assign w_den  = i_den;
            assign w_quo  = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_rem  = r_rem[j-1];
            assign w_den  = r_den[j-1];
            assign w_quo  = r_quo[j-1];
            assign w_side = r_side[j-1];
        end

        assign w_take = (w_rem >> K) >= NW'(w_den);

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_quo[j]  <= w_quo | (w_take ? (QW'(1) << K) : '0);
                r_side[j] <= w_side;
            end
        end

        if (j < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_rem[j] <= w_take ? (w_rem - (NW'(w_den) << K)) : w_rem;
                    r_den[j] <= w_den;
                end
            end
        end
    end

    assign o_quo  = r_quo[QW-1];
    assign o_side = r_side[QW-1];

endmodule

### src/swa_scale.sv
// ----------------------------------------------------------------------------
// swa_scale
// Four-stage back end: window coefficient, ramp and window products, output.
// ----------------------------------------------------------------------------
module swa_scale import swa_pkg::*; #(
    parameter int F  = 16,
    parameter int D  = 1024,
    parameter int QW = 17
) (
    input  logic                       i_clk,
    input  logic [BACK_STAGES-1:0]     i_en,
    input  logic [2:0]                 i_window_type,
    input  logic [QW-1:0]              i_wquo,
    input  logic                       i_wzero,
    input  logic [QW-1:0]              i_rquo,
    input  t_side                      i_side,
    output logic signed [SAMPLE_W-1:0] o_result_re,
    output logic signed [SAMPLE_W-1:0] o_result_im
);

    localparam int LD = $clog2(D);
    localparam int CW = F + 1;
    localparam int PW = SAMPLE_W + CW;
    localparam logic [CW-1:0] ONE = {1'b1, {F{1'b0}}};

    // Cosine table over one full period, fixed at elaboration.
    logic signed [F+1:0] w_cos [D];
    for (genvar k = 0; k < D; k++) begin : g_cos
        assign w_cos[k] = (F + 2)'(swa_cos_entry(k, LD, F));
    end

    // Stage 1: ramp products, capped window ratio and its square, cosine read.
    logic [CW-1:0]       w_rc, w_r;
    logic [2*CW-1:0]     w_rr;
    logic [SAMPLE_W-1:0] w_mre, w_mim;
    logic [PW-1:0]       r1_pre, r1_pim;
    logic [CW-1:0]       r1_r, r1_rr;
    logic signed [F+1:0] r1_cos;
    logic                r1_wzero;
    t_side               r1_side;

    always_comb begin
        w_rc  = i_side.rone ? ONE : i_rquo[CW-1:0];
        w_r   = (i_wquo > QW'(ONE)) ? ONE : i_wquo[CW-1:0];
        w_rr  = (2 * CW)'(w_r) * (2 * CW)'(w_r);
        w_mre = i_side.re[SAMPLE_W-1] ? (~i_side.re + 1'b1) : i_side.re;
        w_mim = i_side.im[SAMPLE_W-1] ? (~i_side.im + 1'b1) : i_side.im;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_pre   <= PW'(w_mre) * PW'(w_rc);
            r1_pim   <= PW'(w_mim) * PW'(w_rc);
            r1_r     <= w_r;
            r1_rr    <= w_rr[F +: CW];
            r1_cos   <= w_cos[i_wquo[LD-1:0]];
            r1_wzero <= i_wzero;
            r1_side  <= i_side;
        end
    end

    // Stage 2: window coefficient and ramp-scaled magnitudes.
    logic [F+2:0]        w_hdiff;
    logic [CW-1:0]       w_wc;
    logic [SAMPLE_W-1:0] r2_mre, r2_mim;
    logic [CW-1:0]       r2_wc;
    t_side               r2_side;

    always_comb begin
        w_hdiff = {2'b00, ONE} - {r1_cos[F+1], r1_cos};
        unique case (t_win'(i_window_type))
            WIN_PARZEN:   w_wc = ONE - r1_r;
            WIN_WELCH:    w_wc = ONE - r1_rr;
            WIN_HANNING:  w_wc = r1_wzero ? '0 : w_hdiff[CW:1];
            WIN_TRIANGLE: w_wc = r1_wzero ? '0 : r1_r;
            default:      w_wc = ONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_mre  <= r1_pre[F +: SAMPLE_W];
            r2_mim  <= r1_pim[F +: SAMPLE_W];
            r2_wc   <= w_wc;
            r2_side <= r1_side;
        end
    end

    // Stage 3: window products.
    logic [PW-1:0] r3_pre, r3_pim;
    t_side         r3_side;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_pre  <= PW'(r2_mre) * PW'(r2_wc);
            r3_pim  <= PW'(r2_mim) * PW'(r2_wc);
            r3_side <= r2_side;
        end
    end

    // Stage 4: restore the sign; samples outside the window pass unchanged.
    logic [SAMPLE_W-1:0] w_m_re, w_m_im, w_v_re, w_v_im;

    always_comb begin
        w_m_re = r3_pre[F +: SAMPLE_W];
        w_m_im = r3_pim[F +: SAMPLE_W];
        w_v_re = r3_side.re[SAMPLE_W-1] ? (~w_m_re + 1'b1) : w_m_re;
        w_v_im = r3_side.im[SAMPLE_W-1] ? (~w_m_im + 1'b1) : w_m_im;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            o_result_re <= r3_side.in_span ? w_v_re : r3_side.re;
            o_result_im <= r3_side.in_span ? w_v_im : r3_side.im;
        end
    end

endmodule

### tb/sv/swa_scoreboard.sv
// ----------------------------------------------------------------------------
// swa_scoreboard
// Watches the configuration port and both item channels of the apodizer,
// predicts each windowed result and compares it with the item that comes out.
// ----------------------------------------------------------------------------
module swa_scoreboard import swa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [16:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [15:0]        i_position,
    input  logic signed [31:0] i_sample_re,
    input  logic signed [31:0] i_sample_im,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_result_re,
    input  logic signed [31:0] i_result_im,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int                LUT_DEPTH = 1024;
    localparam int                FRAC      = 16;
    localparam longint unsigned   UNITY     = 64'd1 << FRAC;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } t_pair;

    logic signed [31:0] cos_lut [LUT_DEPTH];
    t_pair              awaited_q [$];

    logic [2:0]  win_sel;
    logic        pairs_on;
    logic [15:0] span_start;
    logic [15:0] span_stop;
    logic [6:0]  apex_pct;
    logic [16:0] npoints;

    // Cosine of a first-quarter angle in Q30 by a thirteen-term Taylor series.
    function automatic longint unsigned quarter_cos(longint unsigned ang);
        longint unsigned sq;
        longint unsigned term;
        longint          acc;
        sq   = (ang * ang) >> 30;
        term = Q30_ONE;
        acc  = longint'(Q30_ONE);
        for (int i = 1; i <= 12; i++) begin
            term = (term * sq) >> 30;
            term = term / longint'((2 * i - 1) * (2 * i));
            if (i % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) acc = 0;
        if (acc > longint'(Q30_ONE)) acc = longint'(Q30_ONE);
        return longint'(acc);
    endfunction

    initial begin
        longint unsigned ang;
        longint unsigned mag;
        bit              flip;
        for (int k = 0; k < LUT_DEPTH; k++) begin
            ang  = (64'd2 * PI_Q30 * k) / LUT_DEPTH;
            flip = 1'b0;
            if (ang > PI_Q30) ang = 64'd2 * PI_Q30 - ang;
            if (ang > PI_Q30 / 2) begin
                ang  = PI_Q30 - ang;
                flip = 1'b1;
            end
            mag        = quarter_cos(ang) >> (30 - FRAC);
            cos_lut[k] = flip ? -32'(mag) : 32'(mag);
        end
    end

    // Signed value times an unsigned coefficient, truncated towards zero.
    function automatic longint apply_coef(longint x, longint unsigned c);
        longint unsigned m;
        longint unsigned p;
        m = (x < 0) ? longint'(-x) : longint'(x);
        p = (m * c) >> FRAC;
        return (x < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint unsigned taper(longint unsigned n, longint unsigned len);
        longint unsigned gap;
        longint unsigned ratio;
        longint unsigned num;
        longint          cv;
        gap   = (2 * n + 1 >= len) ? (2 * n + 1 - len) : (len - 2 * n - 1);
        ratio = (gap << FRAC) / (len + 1);
        if (ratio > UNITY) ratio = UNITY;
        case (win_sel)
            WIN_PARZEN: return UNITY - ratio;
            WIN_WELCH:  return UNITY - ((ratio * ratio) >> FRAC);
            WIN_HANNING: begin
                if (len < 2) return 0;
                cv = cos_lut[((n * LUT_DEPTH) / (len - 1)) % LUT_DEPTH];
                return longint'(longint'(UNITY) - cv) >> 1;
            end
            WIN_TRIANGLE: begin
                if (len == 0) return 0;
                num = (2 * n <= len) ? 2 * n : 2 * len - 2 * n;
                return (num << FRAC) / len;
            end
            default: return UNITY;
        endcase
    endfunction

    function automatic longint unsigned skew(longint unsigned pos, longint unsigned s,
                                             longint unsigned e);
        longint unsigned pct;
        longint unsigned apex;
        pct = apex_pct;
        if (pct == APEX_OFF) return UNITY;
        if (pct > PERCENT) pct = PERCENT;
        apex = s + ((e - s) * pct) / PERCENT;
        if (pos < apex) return ((pos - s) << FRAC) / (apex - s);
        if (pos < e) return ((e - pos) << FRAC) / (e - apex);
        return UNITY;
    endfunction

    function automatic t_pair windowed(logic [15:0] pos, logic signed [31:0] re,
                                       logic signed [31:0] im);
        longint unsigned s;
        longint unsigned e;
        longint unsigned t;
        longint unsigned rc;
        longint unsigned wc;
        longint          vr;
        longint          vi;
        bit              hit;
        t_pair           res;
        s  = span_start;
        e  = span_stop;
        vr = re;
        vi = pairs_on ? longint'(im) : 0;
        if (s > e) begin
            t = s; s = e; e = t;
        end
        hit = 1'b0;
        if (npoints != 0) begin
            if (e >= npoints) e = npoints - 1;
            hit = (s <= e) && (pos >= s) && (pos <= e);
        end
        if (hit) begin
            rc = skew(pos, s, e);
            wc = taper(pos - s, e - s);
            vr = apply_coef(apply_coef(vr, rc), wc);
            vi = apply_coef(apply_coef(vi, rc), wc);
        end
        res.re = vr[31:0];
        res.im = vi[31:0];
        return res;
    endfunction

    assign o_pending = awaited_q.size();

    always @(posedge i_clk) begin
        t_pair want;
        if (!i_rst_n) begin
            win_sel      <= WIN_SQUARE;
            pairs_on     <= 1'b0;
            span_start   <= 16'd0;
            span_stop    <= 16'hFFFF;
            apex_pct     <= APEX_OFF;
            npoints      <= 17'h10000;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WINDOW_TYPE:   win_sel    <= i_cfg_data[2:0];
                    CFG_COMPLEX_PAIRS: pairs_on   <= i_cfg_data[0];
                    CFG_START_INDEX:   span_start <= i_cfg_data[15:0];
                    CFG_STOP_INDEX:    span_stop  <= i_cfg_data[15:0];
                    CFG_APEX_PERCENT:  apex_pct   <= i_cfg_data[6:0];
                    CFG_POINT_COUNT:   npoints    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                awaited_q.push_back(windowed(i_position, i_sample_re, i_sample_im));
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_q.size() == 0) begin
                    $display("%0t: unexpected result re=%0d im=%0d", $time,
                             i_result_re, i_result_im);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = awaited_q.pop_front();
                    if (want.re !== i_result_re || want.im !== i_result_im) begin
                        $display("%0t: mismatch expected re=%0d im=%0d, got re=%0d im=%0d",
                                 $time, want.re, want.im, i_result_re, i_result_im);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### tb/sv/spectral_window_apodizer_unit_tb.sv
// ----------------------------------------------------------------------------
// spectral_window_apodizer_unit_tb
// Drives samples through the apodizer under a series of window settings and
// lets the scoreboard check every result against its own prediction.
// ----------------------------------------------------------------------------
// The run starts with a handful of directed items at the reset settings,
// covering the sample extremes and both ends of the position range. It then
// steps through window settings that reach every window shape, the apex skew
// ramp at both ends of its range and above it, a swapped span, a zero and a
// clamping point count and the degenerate span lengths. Between settings the
// sender holds back until every result has come home, then leaves the
// pipeline a little longer to drain before any register is touched.
// ----------------------------------------------------------------------------
module spectral_window_apodizer_unit_tb;
    import swa_pkg::*;

    // Well above the pipeline depth, so this comfortably covers a drain.
    localparam int DRAIN_CYCLES = 60;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [16:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [15:0]        i_position;
    logic signed [31:0] i_sample_re;
    logic signed [31:0] i_sample_im;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_result_re;
    logic signed [31:0] o_result_im;

    int fail_count;
    int pending;
    int sent_count;
    int phase_count;
    bit calm;

    spectral_window_apodizer_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_position  (i_position),
        .i_sample_re (i_sample_re),
        .i_sample_im (i_sample_im),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result_re (o_result_re),
        .o_result_im (o_result_im)
    );

    swa_scoreboard scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_position   (i_position),
        .i_sample_re  (i_sample_re),
        .i_sample_im  (i_sample_im),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_result_re  (o_result_re),
        .i_result_im  (o_result_im),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The receiver stalls about a quarter of the time, except in calm stretches.
    always @(posedge i_clk) begin
        i_out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
    end

    // Hard stop in case the pipeline locks up.
    initial begin
        #2000000;
        $display("spectral_window_apodizer_unit_tb NOT OK");
        $finish;
    end

    task automatic cfg_write(t_cfg_idx idx, logic [16:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one item and returns at the edge that accepts it, with valid
    // left high so that a following item can go out back to back.
    task automatic push(logic [15:0] pos, logic [31:0] re, logic [31:0] im);
        if (!calm && $urandom_range(99) < 31) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_position  <= pos;
        i_sample_re <= re;
        i_sample_im <= im;
        do @(posedge i_clk); while (!o_in_ready);
        sent_count++;
    endtask

    // Holds the sender until the pipeline is empty, then lets it settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_window(logic [2:0] wt, logic cplx, logic [15:0] first,
                              logic [15:0] last, logic [6:0] apex, logic [16:0] npts);
        drain();
        cfg_write(CFG_WINDOW_TYPE, 17'(wt));
        cfg_write(CFG_COMPLEX_PAIRS, 17'(cplx));
        cfg_write(CFG_START_INDEX, 17'(first));
        cfg_write(CFG_STOP_INDEX, 17'(last));
        cfg_write(CFG_APEX_PERCENT, 17'(apex));
        cfg_write(CFG_POINT_COUNT, npts);
        phase_count++;
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    // Most positions fall in or just around the span; the rest anywhere.
    task automatic feed(int count, int lo, int hi);
        int          a;
        int          b;
        logic [15:0] pos;
        a = (lo < hi ? lo : hi) - 3;
        b = (lo < hi ? hi : lo) + 3;
        if (a < 0) a = 0;
        if (b > 65535) b = 65535;
        repeat (count) begin
            pos = ($urandom_range(9) < 8) ? 16'($urandom_range(b, a)) : 16'($urandom);
            push(pos, pick_sample(), pick_sample());
        end
    endtask

    initial begin
        logic [15:0] first;
        logic [15:0] last;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_WINDOW_TYPE;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_position  <= '0;
        i_sample_re <= '0;
        i_sample_im <= '0;
        calm        = 1'b0;
        sent_count  = 0;
        phase_count = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: a square window over the whole range, real only.
        push(16'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        push(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        push(16'h5555, 32'hAAAA_AAAA, 32'h5555_5555);
        push(16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        push(16'd1, 32'hFFFF_FFFF, 32'd1);
        push(16'd0, 32'd0, 32'hFFFF_FFFF);

        set_window(WIN_SQUARE, 1'b1, 16'd0, 16'hFFFF, 7'd50, 17'h10000);
        push(16'd0, 32'h8000_0000, 32'h8000_0000);
        push(16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push(16'h5555, 32'hAAAA_AAAA, 32'h5555_5555);
        push(16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA);

        set_window(WIN_PARZEN, 1'b1, 16'd10, 16'd73, 7'd50, 17'h10000);
        feed(70, 10, 73);
        set_window(WIN_HANNING, 1'b1, 16'd0, 16'd200, 7'd50, 17'h10000);
        feed(70, 0, 200);
        // Start above stop, so the span is taken the other way round.
        set_window(WIN_WELCH, 1'b0, 16'd300, 16'd250, 7'd50, 17'h10000);
        feed(70, 250, 300);
        calm = 1'b1;
        set_window(WIN_TRIANGLE, 1'b1, 16'd5, 16'd64, 7'd50, 17'h10000);
        feed(90, 5, 64);
        calm = 1'b0;
        set_window(WIN_SQUARE, 1'b1, 16'd20, 16'd90, 7'd30, 17'h10000);
        feed(70, 20, 90);
        set_window(WIN_HANNING, 1'b1, 16'd1000, 16'd1127, 7'd75, 17'h10000);
        feed(70, 1000, 1127);
        // Zero-length span for the triangle, and a two-point span for Hanning.
        set_window(WIN_TRIANGLE, 1'b1, 16'd0, 16'd0, 7'd50, 17'h10000);
        feed(25, 0, 0);
        set_window(WIN_HANNING, 1'b1, 16'd7, 16'd8, 7'd50, 17'h10000);
        feed(25, 7, 8);
        set_window(WIN_PARZEN, 1'b1, 16'd0, 16'hFFFF, 7'd100, 17'h10000);
        feed(50, 0, 65535);
        // Stop clamped by the point count, with the apex at the very start.
        set_window(WIN_WELCH, 1'b1, 16'd40, 16'd10000, 7'd0, 17'd700);
        feed(60, 40, 720);
        // Unknown window code with the apex beyond full scale.
        set_window(3'd7, 1'b1, 16'd100, 16'd200, 7'd127, 17'h10000);
        feed(50, 100, 200);
        set_window(3'd5, 1'b0, 16'd30, 16'd60, 7'd90, 17'h10000);
        feed(30, 30, 60);
        // Zero points, then a clamp that falls below the start.
        set_window(WIN_PARZEN, 1'b1, 16'd300, 16'd400, 7'd50, 17'd0);
        feed(25, 300, 400);
        set_window(WIN_TRIANGLE, 1'b1, 16'd300, 16'd400, 7'd50, 17'd200);
        feed(25, 190, 400);
        set_window(WIN_HANNING, 1'b0, 16'hFFFF, 16'd0, 7'd20, 17'h10000);
        feed(40, 0, 65535);
        set_window(WIN_WELCH, 1'b1, 16'd0, 16'hFFFF, 7'd50, 17'd1);
        feed(25, 0, 3);
        set_window(WIN_HANNING, 1'b1, 16'd0, 16'd2, 7'd50, 17'h10000);
        feed(25, 0, 2);

        // Random settings, mostly with short spans so every shape is visible.
        repeat (8) begin
            first = 16'($urandom_range(2000));
            last  = first + 16'($urandom_range(300));
            if ($urandom_range(1)) {first, last} = {last, first};
            set_window(3'($urandom_range(7)), 1'($urandom), first, last,
                       7'($urandom_range(127)),
                       ($urandom_range(3) == 0) ? 17'($urandom_range(2400)) : 17'h10000);
            feed(40, int'(first), int'(last));
        end

        drain();
        $display("Sent %0d items across %0d window settings, covering every shape,",
                 sent_count, phase_count);
        $display("apex skew, swapped and clamped spans and empty point counts.");
        if (fail_count == 0) begin
            $display("spectral_window_apodizer_unit_tb OK");
        end else begin
            $display("spectral_window_apodizer_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
